### design/mrpt_pkg.sv
// Package for the Miller-Rabin prime test: widths, limits, witnesses,
// control word layout and the microprogram that drives the datapath.
// No dependencies.
package mrpt_pkg;

   localparam int CAND_W = 64;
   localparam int NW     = 24;
   localparam int SW     = 5;
   localparam int PC_W   = 5;
   localparam int RSP_W  = 8;

   localparam logic [CAND_W-1:0] LIMIT_LOW  = CAND_W'(1373653);
   localparam logic [CAND_W-1:0] LIMIT_HIGH = CAND_W'(9080191);

   localparam logic [NW-1:0] WIT_LOW_A  = NW'(2);
   localparam logic [NW-1:0] WIT_LOW_B  = NW'(3);
   localparam logic [NW-1:0] WIT_HIGH_A = NW'(31);
   localparam logic [NW-1:0] WIT_HIGH_B = NW'(73);

   localparam logic [3:0] ACT_NONE   = 4'd0;
   localparam logic [3:0] ACT_LOAD   = 4'd1;
   localparam logic [3:0] ACT_HALVE  = 4'd2;
   localparam logic [3:0] ACT_WINIT  = 4'd3;
   localparam logic [3:0] ACT_MUL_RX = 4'd4;
   localparam logic [3:0] ACT_MUL_XX = 4'd5;
   localparam logic [3:0] ACT_SHR_E  = 4'd6;
   localparam logic [3:0] ACT_TINIT  = 4'd7;
   localparam logic [3:0] ACT_MUL_RR = 4'd8;
   localparam logic [3:0] ACT_DEC_T  = 4'd9;
   localparam logic [3:0] ACT_NEXT_W = 4'd10;
   localparam logic [3:0] ACT_PRIME  = 4'd11;
   localparam logic [3:0] ACT_FAIL   = 4'd12;
   localparam logic [3:0] ACT_SEND   = 4'd13;

   localparam logic [3:0] COND_NEVER     = 4'd0;
   localparam logic [3:0] COND_ALWAYS    = 4'd1;
   localparam logic [3:0] COND_NO_ACCEPT = 4'd2;
   localparam logic [3:0] COND_EARLY     = 4'd3;
   localparam logic [3:0] COND_D_EVEN    = 4'd4;
   localparam logic [3:0] COND_E_ZERO    = 4'd5;
   localparam logic [3:0] COND_E_EVEN    = 4'd6;
   localparam logic [3:0] COND_R_ONE     = 4'd7;
   localparam logic [3:0] COND_T_ZERO    = 4'd8;
   localparam logic [3:0] COND_R_NM1     = 4'd9;
   localparam logic [3:0] COND_W_LAST    = 4'd10;
   localparam logic [3:0] COND_OUT_FREE  = 4'd11;

   localparam logic [PC_W-1:0] ST_IDLE   = 5'd0;
   localparam logic [PC_W-1:0] ST_CHECK  = 5'd1;
   localparam logic [PC_W-1:0] ST_STRIP  = 5'd2;
   localparam logic [PC_W-1:0] ST_WINIT  = 5'd3;
   localparam logic [PC_W-1:0] ST_PTEST  = 5'd4;
   localparam logic [PC_W-1:0] ST_PBIT   = 5'd5;
   localparam logic [PC_W-1:0] ST_PMUL   = 5'd6;
   localparam logic [PC_W-1:0] ST_PSQ    = 5'd7;
   localparam logic [PC_W-1:0] ST_PSHIFT = 5'd8;
   localparam logic [PC_W-1:0] ST_CHK1   = 5'd9;
   localparam logic [PC_W-1:0] ST_TINIT  = 5'd10;
   localparam logic [PC_W-1:0] ST_TLOOP  = 5'd11;
   localparam logic [PC_W-1:0] ST_TCMP   = 5'd12;
   localparam logic [PC_W-1:0] ST_TSQ    = 5'd13;
   localparam logic [PC_W-1:0] ST_TDEC   = 5'd14;
   localparam logic [PC_W-1:0] ST_PASS   = 5'd15;
   localparam logic [PC_W-1:0] ST_RETRY  = 5'd16;
   localparam logic [PC_W-1:0] ST_PRIME  = 5'd17;
   localparam logic [PC_W-1:0] ST_FAIL   = 5'd18;
   localparam logic [PC_W-1:0] ST_SEND   = 5'd19;
   localparam logic [PC_W-1:0] ST_WAIT   = 5'd20;

   typedef struct packed {
      logic [3:0]      act;
      logic [3:0]      cond;
      logic [PC_W-1:0] target;
   } ctl_type;

   function automatic ctl_type mk(input logic [3:0] act, input logic [3:0] cond,
                                  input logic [PC_W-1:0] target);
      ctl_type c;
      c.act    = act;
      c.cond   = cond;
      c.target = target;
      return c;
   endfunction

   function automatic ctl_type rom(input logic [PC_W-1:0] pc);
      ctl_type c;
      case (pc)
         ST_IDLE:   c = mk(ACT_LOAD,   COND_NO_ACCEPT, ST_IDLE);
         ST_CHECK:  c = mk(ACT_NONE,   COND_EARLY,     ST_SEND);
         ST_STRIP:  c = mk(ACT_HALVE,  COND_D_EVEN,    ST_STRIP);
         ST_WINIT:  c = mk(ACT_WINIT,  COND_NEVER,     ST_IDLE);
         ST_PTEST:  c = mk(ACT_NONE,   COND_E_ZERO,    ST_CHK1);
         ST_PBIT:   c = mk(ACT_NONE,   COND_E_EVEN,    ST_PSQ);
         ST_PMUL:   c = mk(ACT_MUL_RX, COND_NEVER,     ST_IDLE);
         ST_PSQ:    c = mk(ACT_MUL_XX, COND_NEVER,     ST_IDLE);
         ST_PSHIFT: c = mk(ACT_SHR_E,  COND_ALWAYS,    ST_PTEST);
         ST_CHK1:   c = mk(ACT_NONE,   COND_R_ONE,     ST_PASS);
         ST_TINIT:  c = mk(ACT_TINIT,  COND_NEVER,     ST_IDLE);
         ST_TLOOP:  c = mk(ACT_NONE,   COND_T_ZERO,    ST_FAIL);
         ST_TCMP:   c = mk(ACT_NONE,   COND_R_NM1,     ST_PASS);
         ST_TSQ:    c = mk(ACT_MUL_RR, COND_NEVER,     ST_IDLE);
         ST_TDEC:   c = mk(ACT_DEC_T,  COND_ALWAYS,    ST_TLOOP);
         ST_PASS:   c = mk(ACT_NEXT_W, COND_W_LAST,    ST_PRIME);
         ST_RETRY:  c = mk(ACT_NONE,   COND_ALWAYS,    ST_WINIT);
         ST_PRIME:  c = mk(ACT_PRIME,  COND_ALWAYS,    ST_SEND);
         ST_FAIL:   c = mk(ACT_FAIL,   COND_NEVER,     ST_IDLE);
         ST_SEND:   c = mk(ACT_SEND,   COND_OUT_FREE,  ST_IDLE);
         ST_WAIT:   c = mk(ACT_NONE,   COND_ALWAYS,    ST_SEND);
         default:   c = mk(ACT_NONE,   COND_ALWAYS,    ST_IDLE);
      endcase
      return c;
   endfunction

endpackage

### design/miller_rabin_prime_test.sv
// Deterministic Miller-Rabin prime test, microcoded sequencer over a small
// datapath with a bit-serial modular multiplier. Depends on mrpt_pkg.
//
//   channel | dir | handshake            | payload
//   req     | in  | req_tvalid/tready    | tdata[63:0] candidate
//   rsp     | out | rsp_tvalid/tready    | tdata[0] is_prime, [1] out_of_range
//
// One item at a time. Trivial candidates (below 4, even, or at or above the
// range limit) are answered from the check state without the multiplier.
// Others run modular multiplications, each a load step and 24 multiplier
// bits, at most 94 of them over both witnesses, plus control steps for
// each exponent bit and each squaring round.
// Reset returns the step counter to idle and clears the response valid flag.
// A waiting result holds while the next item is taken and worked on.
module miller_rabin_prime_test (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [mrpt_pkg::CAND_W-1:0]  req_tdata,   // [63:0] candidate
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [mrpt_pkg::RSP_W-1:0]   rsp_tdata    // [0] is_prime, [1] out_of_range
);
   import mrpt_pkg::*;

   logic [PC_W-1:0] pc_ff, pc_in;
   logic [NW-1:0]   n_ff, n_in, d_ff, d_in, e_ff, e_in, r_ff, r_in, x_ff, x_in;
   logic [SW-1:0]   s_ff, s_in, t_ff, t_in;
   logic            hi_ff, hi_in, wit_ff, wit_in, early_ff, early_in;
   logic [1:0]      res_ff, res_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [1:0]      rsp_data_ff, rsp_data_in;

   logic            mm_busy_ff, mm_busy_in;
   logic [SW-1:0]   mm_cnt_ff, mm_cnt_in;
   logic [NW-1:0]   mm_p_ff, mm_p_in, mm_q_ff, mm_q_in, mm_acc_ff, mm_acc_in;
   logic [NW+1:0]   mm_t1, mm_t2, mm_t3, n_ext;

   ctl_type         ctl;
   logic            accept, is_mul, mul_done, cond_ok, out_free;
   logic [NW-1:0]   nm1, mul_a, mul_b, witness;
   logic [CAND_W-1:0] cand;
   logic            c_oor, c_small, c_tiny_prime, c_even;

   assign ctl        = rom(pc_ff);
   assign req_tready = (pc_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign nm1        = n_ff - NW'(1);
   assign n_ext      = {2'b00, n_ff};
   assign cand       = req_tdata;

   assign c_oor        = (cand >= LIMIT_HIGH);
   assign c_small      = (cand < CAND_W'(2));
   assign c_tiny_prime = !c_small && (cand < CAND_W'(4));
   assign c_even       = !cand[0];

   assign is_mul   = (ctl.act == ACT_MUL_RX) || (ctl.act == ACT_MUL_XX) ||
                     (ctl.act == ACT_MUL_RR);
   assign mul_done = mm_busy_ff && (mm_cnt_ff == '0);

   always_comb begin
      case ({hi_ff, wit_ff})
         2'b00:   witness = WIT_LOW_A;
         2'b01:   witness = WIT_LOW_B;
         2'b10:   witness = WIT_HIGH_A;
         2'b11:   witness = WIT_HIGH_B;
         default: witness = WIT_LOW_A;
      endcase
   end

   always_comb begin
      case (ctl.act)
         ACT_MUL_RX: begin mul_a = r_ff; mul_b = x_ff; end
         ACT_MUL_XX: begin mul_a = x_ff; mul_b = x_ff; end
         default:    begin mul_a = r_ff; mul_b = r_ff; end
      endcase
   end

   // one multiplier bit per cycle, MSB first, with reduction below n
   assign mm_t1 = {1'b0, mm_acc_ff, 1'b0} + {2'b00, (mm_p_ff[NW-1] ? mm_q_ff : '0)};
   assign mm_t2 = (mm_t1 >= n_ext) ? mm_t1 - n_ext : mm_t1;
   assign mm_t3 = (mm_t2 >= n_ext) ? mm_t2 - n_ext : mm_t2;

   always_comb begin
      case (ctl.cond)
         COND_NEVER:     cond_ok = 1'b0;
         COND_ALWAYS:    cond_ok = 1'b1;
         COND_NO_ACCEPT: cond_ok = !accept;
         COND_EARLY:     cond_ok = early_ff;
         COND_D_EVEN:    cond_ok = !d_ff[0];
         COND_E_ZERO:    cond_ok = (e_ff == '0);
         COND_E_EVEN:    cond_ok = !e_ff[0];
         COND_R_ONE:     cond_ok = (r_ff == NW'(1));
         COND_T_ZERO:    cond_ok = (t_ff == '0);
         COND_R_NM1:     cond_ok = (r_ff == nm1);
         COND_W_LAST:    cond_ok = wit_ff;
         COND_OUT_FREE:  cond_ok = out_free;
         default:        cond_ok = 1'b0;
      endcase
   end

   always_comb begin
      pc_in        = pc_ff;
      n_in         = n_ff;
      d_in         = d_ff;
      e_in         = e_ff;
      r_in         = r_ff;
      x_in         = x_ff;
      s_in         = s_ff;
      t_in         = t_ff;
      hi_in        = hi_ff;
      wit_in       = wit_ff;
      early_in     = early_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      mm_busy_in   = mm_busy_ff;
      mm_cnt_in    = mm_cnt_ff;
      mm_p_in      = mm_p_ff;
      mm_q_in      = mm_q_ff;
      mm_acc_in    = mm_acc_ff;

      if (is_mul) begin
         if (!mm_busy_ff) begin
            mm_busy_in = 1'b1;
            mm_cnt_in  = SW'(NW - 1);
            mm_p_in    = mul_a;
            mm_q_in    = mul_b;
            mm_acc_in  = '0;
         end else begin
            mm_acc_in = mm_t3[NW-1:0];
            mm_p_in   = {mm_p_ff[NW-2:0], 1'b0};
            mm_cnt_in = mm_cnt_ff - SW'(1);
            if (mul_done) begin
               mm_busy_in = 1'b0;
               if (ctl.act == ACT_MUL_XX) begin
                  x_in = mm_t3[NW-1:0];
               end else begin
                  r_in = mm_t3[NW-1:0];
               end
               pc_in = pc_ff + PC_W'(1);
            end
         end
      end else begin
         pc_in = cond_ok ? ctl.target : pc_ff + PC_W'(1);
      end

      case (ctl.act)
         ACT_LOAD: begin
            if (accept) begin
               n_in     = cand[NW-1:0];
               d_in     = cand[NW-1:0] - NW'(1);
               s_in     = '0;
               wit_in   = 1'b0;
               hi_in    = (cand >= LIMIT_LOW);
               early_in = c_oor || c_small || c_tiny_prime || c_even;
               res_in   = {c_oor, !c_oor && c_tiny_prime};
            end
         end
         ACT_HALVE: begin
            if (!d_ff[0]) begin
               d_in = {1'b0, d_ff[NW-1:1]};
               s_in = s_ff + SW'(1);
            end
         end
         ACT_WINIT: begin
            r_in = NW'(1);
            x_in = witness;
            e_in = d_ff;
         end
         ACT_SHR_E:  e_in = {1'b0, e_ff[NW-1:1]};
         ACT_TINIT:  t_in = s_ff;
         ACT_DEC_T:  t_in = t_ff - SW'(1);
         ACT_NEXT_W: wit_in = !wit_ff;
         ACT_PRIME:  res_in = 2'b01;
         ACT_FAIL:   res_in = 2'b00;
         ACT_SEND: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         mm_busy_ff   <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
         mm_busy_ff   <= mm_busy_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      d_ff        <= d_in;
      e_ff        <= e_in;
      r_ff        <= r_in;
      x_ff        <= x_in;
      s_ff        <= s_in;
      t_ff        <= t_in;
      hi_ff       <= hi_in;
      wit_ff      <= wit_in;
      early_ff    <= early_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
      mm_cnt_ff   <= mm_cnt_in;
      mm_p_ff     <= mm_p_in;
      mm_q_ff     <= mm_q_in;
      mm_acc_ff   <= mm_acc_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_W-2){1'b0}}, rsp_data_ff};

endmodule
